// ===== hdl/drtm_pkg.sv =====
// Shared types and constants of the dark-subtracted region threshold mean block.
package drtm_pkg;

  localparam int COORD_W    = 7;
  localparam int SAMPLE_W   = 18;
  localparam int DARK_W     = 18;
  localparam int THR_W      = 19;
  localparam int MEAN_W     = 19;
  localparam int COUNT_W    = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;

  localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Saturation limits of the mean, as magnitudes and as signed codes.
  localparam longint MEAN_MAG_POS = (64'd1 << (MEAN_W - 1)) - 1;
  localparam longint MEAN_MAG_NEG = (64'd1 << (MEAN_W - 1));
  localparam logic signed [MEAN_W-1:0] MEAN_SAT_HI = {1'b0, {(MEAN_W-1){1'b1}}};
  localparam logic signed [MEAN_W-1:0] MEAN_SAT_LO = {1'b1, {(MEAN_W-1){1'b0}}};

  typedef enum logic {
    OP_PIXEL      = 1'b0,
    OP_DARK_WRITE = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD    = 3'd0,
    REG_COL_CORNER_A = 3'd1,
    REG_COL_CORNER_B = 3'd2,
    REG_ROW_CORNER_A = 3'd3,
    REG_ROW_CORNER_B = 3'd4
  } cfg_reg_t;

endpackage

// ===== hdl/drtm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module drtm_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/drtm_div.sv =====
// Bit-serial restoring divider for unsigned magnitudes, one quotient bit per cycle.
module drtm_div #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 15
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] acc;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] divisor;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   trial;
  logic             fits;

  // The dividend shifts out of the top of acc while quotient bits enter at the bottom.
  assign rem_sh = {rem, acc[NUM_W-1]};
  assign trial  = rem_sh - {1'b0, divisor};
  assign fits   = ~trial[DEN_W];
  assign quot   = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            acc     <= num;
            divisor <= den;
            rem     <= '0;
            cnt     <= CNT_W'(NUM_W);
            state   <= S_RUN;
          end
        end
        S_RUN: begin
          acc <= {acc[NUM_W-2:0], fits};
          rem <= fits ? trial[DEN_W-1:0] : rem_sh[DEN_W-1:0];
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/dark_subtracted_roi_threshold_mean.sv =====
// A dark write lands in the RAM at acceptance; a pixel reads the dark frame, then accumulates.
// A pixel with frame_end then closes the frame and starts the bit-serial divider, which
// produces one quotient bit per cycle; an empty frame skips the divider.
// Throughput: one dark write per cycle while idle; the input stalls during a pixel's lookup,
// a frame close, a divide and while a finished result waits for the output register to free up.
// Synchronous active-high reset clears sum, count, threshold and handshakes, widens the region
// to all coordinates; the dark frame RAM is not cleared and holds undefined data until written.
module dark_subtracted_roi_threshold_mean #(
  parameter int FRAME_COLS  = 128,
  parameter int FRAME_ROWS  = 128,
  parameter int SAMPLE_BITS = 14,
  parameter int FRAC_BITS   = 4
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // Configuration write port.
  input  logic                                   cfg_wr_en,
  input  logic [drtm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [drtm_pkg::CFG_DATA_W-1:0]        cfg_data,
  // Input channel.
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   operation,
  input  logic [drtm_pkg::COORD_W-1:0]           col,
  input  logic [drtm_pkg::COORD_W-1:0]           row,
  input  logic [drtm_pkg::SAMPLE_W-1:0]          sample,
  input  logic                                   frame_end,
  // Result channel.
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [drtm_pkg::MEAN_W-1:0]     mean_offset,
  output logic [drtm_pkg::COUNT_W-1:0]           pixel_count,
  output logic                                   empty_res
);

  import drtm_pkg::*;

  // Derived widths. The difference is one bit wider than the wider operand so it never wraps,
  // and the sum has room for COUNT_MAX differences of full scale.
  localparam int DEPTH  = FRAME_COLS * FRAME_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LVL_W  = SAMPLE_BITS + FRAC_BITS;
  localparam int DIFF_W = ((LVL_W > DARK_W) ? LVL_W : DARK_W) + 1;
  localparam int SUM_W  = DIFF_W + COUNT_W;

  // The sequencer walks one transaction through its steps. IDLE takes a transaction, LOOKUP
  // has the dark value from the RAM and accumulates, FRAME closes a frame and starts the
  // divider unless the frame is empty, DIVIDE waits for the quotient and saturates it, DONE
  // hands the result to the output register once that register is free.
  typedef enum logic [2:0] {
    IDLE,
    LOOKUP,
    FRAME,
    DIVIDE,
    DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic signed [THR_W-1:0] threshold;
  logic [COORD_W-1:0]      col_corner_a;
  logic [COORD_W-1:0]      col_corner_b;
  logic [COORD_W-1:0]      row_corner_a;
  logic [COORD_W-1:0]      row_corner_b;

  // Pixel held across the RAM read.
  logic             pix_hit;
  logic             pix_fend;
  logic [LVL_W-1:0] pix_level;

  // Frame accumulation.
  logic signed [SUM_W-1:0] diff_sum;
  logic [COUNT_W-1:0]      qualified_count;

  // Result being formed.
  logic                     sum_neg;
  logic signed [MEAN_W-1:0] res_mean;
  logic [COUNT_W-1:0]       res_count;
  logic                     res_empty;

  // Input decode.
  logic               accept;
  logic               inside_frame;
  logic               in_region;
  logic [COORD_W-1:0] col_lo;
  logic [COORD_W-1:0] col_hi;
  logic [COORD_W-1:0] row_lo;
  logic [COORD_W-1:0] row_hi;
  logic [ADDR_W-1:0]  addr;
  logic               ram_wr_en;
  logic               ram_rd_en;
  logic [DARK_W-1:0]  dark_value;

  // Accumulate step.
  logic signed [DIFF_W-1:0] diff;
  logic                     qualify;

  // Divider hookup.
  logic             div_start;
  logic             div_done;
  logic [SUM_W-1:0] sum_abs;
  logic [SUM_W-1:0] div_quot;

  assign in_ready = (state == IDLE);
  assign accept   = in_valid && in_ready;

  // The region corners may be written in either order, so each pair is sorted here.
  assign col_lo = (col_corner_a < col_corner_b) ? col_corner_a : col_corner_b;
  assign col_hi = (col_corner_a < col_corner_b) ? col_corner_b : col_corner_a;
  assign row_lo = (row_corner_a < row_corner_b) ? row_corner_a : row_corner_b;
  assign row_hi = (row_corner_a < row_corner_b) ? row_corner_b : row_corner_a;

  assign inside_frame = (32'(col) < FRAME_COLS) && (32'(row) < FRAME_ROWS);
  assign in_region    = (col >= col_lo) && (col <= col_hi) && (row >= row_lo) && (row <= row_hi);
  assign addr         = ADDR_W'(32'(row) * FRAME_COLS + 32'(col));

  // A dark write lands in the RAM at acceptance; coordinates outside the frame are dropped.
  assign ram_wr_en = accept && (operation == OP_DARK_WRITE) && inside_frame;
  assign ram_rd_en = accept && (operation == OP_PIXEL);

  drtm_ram #(
    .WIDTH (DARK_W),
    .DEPTH (DEPTH)
  ) u_dark_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (addr),
    .wr_data (sample[DARK_W-1:0]),
    .rd_en   (ram_rd_en),
    .rd_addr (addr),
    .rd_data (dark_value)
  );

  // Dark subtraction and the threshold test. Both operands are zero-extended, so the
  // difference is exact; the compare against the signed threshold extends both sides.
  always_comb begin
    diff    = $signed({{(DIFF_W-LVL_W){1'b0}}, pix_level})
            - $signed({{(DIFF_W-DARK_W){1'b0}}, dark_value});
    qualify = pix_hit && (diff <= threshold) && (qualified_count != COUNT_MAX);
  end

  // The divider works on magnitudes; the sign is put back after the quotient is known.
  assign sum_abs   = diff_sum[SUM_W-1] ? (~diff_sum + SUM_W'(1)) : diff_sum;
  assign div_start = (state == FRAME) && (qualified_count != '0);

  drtm_div #(
    .NUM_W (SUM_W),
    .DEN_W (COUNT_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (sum_abs),
    .den   (qualified_count),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= IDLE;
      out_valid       <= 1'b0;
      diff_sum        <= '0;
      qualified_count <= '0;
      threshold       <= '0;
      col_corner_a    <= '0;
      col_corner_b    <= COORD_MAX;
      row_corner_a    <= '0;
      row_corner_b    <= COORD_MAX;
    end else begin
      // User sends configuration writes only when idle (unchecked); unknown indexes do nothing.
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_THRESHOLD:    threshold    <= cfg_data[THR_W-1:0];
          REG_COL_CORNER_A: col_corner_a <= cfg_data[COORD_W-1:0];
          REG_COL_CORNER_B: col_corner_b <= cfg_data[COORD_W-1:0];
          REG_ROW_CORNER_A: row_corner_a <= cfg_data[COORD_W-1:0];
          REG_ROW_CORNER_B: row_corner_b <= cfg_data[COORD_W-1:0];
          default: ;
        endcase
      end

      // The output register frees itself when the result transaction completes, unless a
      // new result moves into it at the same edge.
      if (out_valid && out_ready && (state != DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        IDLE: begin
          // A dark write with frame_end produces no result, so it never leaves IDLE.
          if (accept && (operation == OP_PIXEL)) begin
            pix_hit   <= inside_frame && in_region;
            pix_fend  <= frame_end;
            pix_level <= LVL_W'(sample[SAMPLE_BITS-1:0]) << FRAC_BITS;
            state     <= LOOKUP;
          end
        end
        LOOKUP: begin
          if (qualify) begin
            diff_sum        <= diff_sum + {{(SUM_W-DIFF_W){diff[DIFF_W-1]}}, diff};
            qualified_count <= qualified_count + COUNT_W'(1);
          end
          state <= pix_fend ? FRAME : IDLE;
        end
        FRAME: begin
          // An empty frame skips the divider and reports zero with the empty flag.
          res_count       <= qualified_count;
          sum_neg         <= diff_sum[SUM_W-1];
          res_empty       <= (qualified_count == '0);
          res_mean        <= '0;
          diff_sum        <= '0;
          qualified_count <= '0;
          state           <= (qualified_count == '0) ? DONE : DIVIDE;
        end
        DIVIDE: begin
          if (div_done) begin
            if (sum_neg) begin
              res_mean <= (div_quot > SUM_W'(MEAN_MAG_NEG)) ? MEAN_SAT_LO
                                                            : MEAN_W'(~div_quot + SUM_W'(1));
            end else begin
              res_mean <= (div_quot > SUM_W'(MEAN_MAG_POS)) ? MEAN_SAT_HI
                                                            : MEAN_W'(div_quot);
            end
            state <= DONE;
          end
        end
        DONE: begin
          if (!out_valid || out_ready) begin
            mean_offset <= res_mean;
            pixel_count <= res_count;
            empty_res   <= res_empty;
            out_valid   <= 1'b1;
            state       <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/drtm_checker.sv =====
// Port-level checker for the region threshold mean block, bound to its top level.
module drtm_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               operation,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [drtm_pkg::MEAN_W-1:0] mean_offset,
  input logic [drtm_pkg::COUNT_W-1:0]       pixel_count,
  input logic                               empty_res
);

  import drtm_pkg::*;

  // A result that waits for the consumer keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mean_offset) && $stable(pixel_count)
                                && $stable(empty_res))
    else $error("result changed while stalled");

  // An empty frame reports a zero mean and a zero count.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_res |-> (pixel_count == '0) && (mean_offset == '0))
    else $error("empty result carries data");

  // A non-empty result always has at least one counted pixel.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !empty_res |-> (pixel_count != '0))
    else $error("non-empty result with zero count");

  // A pixel needs a dark frame lookup, so the input side stalls for the next cycle.
  a_pixel_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (operation == OP_PIXEL) |=> !in_ready)
    else $error("pixel accepted without lookup stall");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind dark_subtracted_roi_threshold_mean drtm_checker u_drtm_checker (.*);
